// ----- src/gmlt_pkg.sv -----
package gmlt_pkg;

	localparam int GROUP_SLOTS_DEF  = 16;
	localparam int MEMBER_SLOTS_DEF = 32;
	localparam int LINK_SLOTS_DEF   = 64;
	localparam int ID_BITS_DEF      = 16;

	localparam int OPCODE_W = 3;
	localparam int FIELD_ID_W = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 7;
	localparam int STAMP_W = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ADD_GROUP  = 3'd0,
		OP_FIND_GROUP = 3'd1,
		OP_DEL_GROUP  = 3'd2,
		OP_ADD_MEMBER = 3'd3,
		OP_FIND_MEMBER = 3'd4,
		OP_DEL_MEMBER = 3'd5,
		OP_ADD_LINK   = 3'd6,
		OP_COUNT      = 3'd7
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GADD,
		S_GSCAN,
		S_MADD,
		S_MSCAN,
		S_LSCAN,
		S_LADD,
		S_DONE
	} state_t;

	typedef struct packed {
		opcode_t                 opcode;
		logic [FIELD_ID_W-1:0]   group_id;
		logic [FIELD_ID_W-1:0]   member_id;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [COUNT_W-1:0]    member_count;
	} rsp_t;

endpackage

// ----- src/gmlt_rsp_reg.sv -----
module gmlt_rsp_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gmlt_pkg::rsp_t push_data,
	output logic          push_ready,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output gmlt_pkg::rsp_t rsp
);

	logic          valid_q;
	gmlt_pkg::rsp_t data_q;

	// The register can be reloaded in the same cycle its content is taken.
	assign push_ready = !valid_q || !rsp_stall;
	assign rsp_valid  = valid_q;
	assign rsp        = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push && push_ready) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			data_q <= push_data;
		end
	end

endmodule

// ----- src/group_member_link_table.sv -----
// Group / member link table.
// Requests arrive on req (opcode, group_id, member_id) under req_valid and
// req_stall; one result per request leaves on rsp (status, member_count) under
// rsp_valid and rsp_stall. A transfer happens at a clock edge where valid is
// high and stall is low.
// The block works on one request at a time. Ids, insertion stamps and link
// endpoints live in three synchronous memories that are walked one entry per
// cycle; the used flags sit in flip-flops. An add walks the used flags up to the
// first free slot (an add link first looks up its group and member), a lookup
// walks the group or member memory, and deletes and counts walk the link memory
// after their group or member lookup. An add into an empty table goes from the
// add state to the done state, which loads the result into the output register;
// an add link that finds the link table full first walks the group, member and
// link slots. The next request is taken in the cycle after the result loads.
// The result sits in an output register, so a finished result may wait for the
// receiver while the next request is taken; if the register is still occupied
// and stalled when a further result is ready, that result waits and req_stall
// stays high.
// Reset clears every used flag and the insertion stamp at once, so the block
// takes a request in the first cycle after reset is released.
module group_member_link_table #(
	parameter int GROUP_SLOTS  = gmlt_pkg::GROUP_SLOTS_DEF,
	parameter int MEMBER_SLOTS = gmlt_pkg::MEMBER_SLOTS_DEF,
	parameter int LINK_SLOTS   = gmlt_pkg::LINK_SLOTS_DEF,
	parameter int ID_BITS      = gmlt_pkg::ID_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  gmlt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output gmlt_pkg::rsp_t rsp
);

	localparam int GW = $clog2(GROUP_SLOTS);
	localparam int MW = $clog2(MEMBER_SLOTS);
	localparam int LW = $clog2(LINK_SLOTS);
	localparam int MAXS = (LINK_SLOTS > GROUP_SLOTS) ?
		((LINK_SLOTS > MEMBER_SLOTS) ? LINK_SLOTS : MEMBER_SLOTS) :
		((GROUP_SLOTS > MEMBER_SLOTS) ? GROUP_SLOTS : MEMBER_SLOTS);
	localparam int SCW = $clog2(MAXS + 1);
	localparam int SW = gmlt_pkg::STAMP_W;
	localparam int CW = gmlt_pkg::COUNT_W;
	localparam logic [SCW-1:0] G_LIM = SCW'(GROUP_SLOTS);
	localparam logic [SCW-1:0] M_LIM = SCW'(MEMBER_SLOTS);
	localparam logic [SCW-1:0] L_LIM = SCW'(LINK_SLOTS);
	localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

	gmlt_pkg::state_t  state_q, state_d;
	gmlt_pkg::opcode_t op_q;
	gmlt_pkg::status_t status_q;
	logic [ID_BITS-1:0] gid_q, mid_q;
	logic [SCW-1:0]     cnt_q, idx_s1;
	logic               v_s1;
	logic [GW-1:0]      gbest_q;
	logic [MW-1:0]      mbest_q;
	logic               gfound_q, mfound_q;
	logic [SW-1:0]      gbest_age_q, mbest_age_q, stamp_q;
	logic [CW-1:0]      count_q;
	logic [GROUP_SLOTS-1:0]  gused_q, gmatch_q;
	logic [MEMBER_SLOTS-1:0] mused_q;
	logic [LINK_SLOTS-1:0]   lused_q;

	// Storage: id and stamp per group and member slot, endpoints per link.
	logic [ID_BITS+SW-1:0] gmem [GROUP_SLOTS];
	logic [ID_BITS+SW-1:0] mmem [MEMBER_SLOTS];
	logic [GW+MW-1:0]      lmem [LINK_SLOTS];
	logic [ID_BITS+SW-1:0] g_rd_s1, m_rd_s1;
	logic [GW+MW-1:0]      l_rd_s1;

	logic [GW-1:0] g_ca, g_i1;
	logic [MW-1:0] m_ca, m_i1;
	logic [LW-1:0] l_ca, l_i1;
	logic [ID_BITS-1:0] g_rd_key, m_rd_key;
	logic [SW-1:0]      g_rd_age, m_rd_age;
	logic [GW-1:0]      l_rd_g;
	logic [MW-1:0]      l_rd_m;

	logic accept, issue, cnt_inc, g_we, m_we, l_we, st_set, push, push_ready;
	logic clr_gused, clr_mused;
	logic g_done, m_done, l_done;
	gmlt_pkg::status_t st_val;
	gmlt_pkg::rsp_t    push_data;

	assign g_ca = cnt_q[GW-1:0];
	assign m_ca = cnt_q[MW-1:0];
	assign l_ca = cnt_q[LW-1:0];
	assign g_i1 = idx_s1[GW-1:0];
	assign m_i1 = idx_s1[MW-1:0];
	assign l_i1 = idx_s1[LW-1:0];
	assign {g_rd_key, g_rd_age} = g_rd_s1;
	assign {m_rd_key, m_rd_age} = m_rd_s1;
	assign {l_rd_g, l_rd_m} = l_rd_s1;

	// A walk is over once the last address was issued and its data evaluated.
	assign g_done = (cnt_q == G_LIM) && !v_s1;
	assign m_done = (cnt_q == M_LIM) && !v_s1;
	assign l_done = (cnt_q == L_LIM) && !v_s1;

	assign accept = req_valid && !req_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gmlt_pkg::S_IDLE: begin
				if (accept) begin
					unique case (req.opcode)
						gmlt_pkg::OP_ADD_GROUP:  state_d = gmlt_pkg::S_GADD;
						gmlt_pkg::OP_ADD_MEMBER: state_d = gmlt_pkg::S_MADD;
						gmlt_pkg::OP_FIND_MEMBER,
						gmlt_pkg::OP_DEL_MEMBER: state_d = gmlt_pkg::S_MSCAN;
						default:                 state_d = gmlt_pkg::S_GSCAN;
					endcase
				end
			end
			gmlt_pkg::S_GADD: begin
				if (cnt_q == G_LIM || !gused_q[g_ca]) begin
					state_d = gmlt_pkg::S_DONE;
				end
			end
			gmlt_pkg::S_MADD: begin
				if (cnt_q == M_LIM || !mused_q[m_ca]) begin
					state_d = gmlt_pkg::S_DONE;
				end
			end
			gmlt_pkg::S_LADD: begin
				if (cnt_q == L_LIM || !lused_q[l_ca]) begin
					state_d = gmlt_pkg::S_DONE;
				end
			end
			gmlt_pkg::S_GSCAN: begin
				if (g_done) begin
					priority if (op_q == gmlt_pkg::OP_COUNT) begin
						state_d = gmlt_pkg::S_LSCAN;
					end else if (gfound_q && op_q == gmlt_pkg::OP_DEL_GROUP) begin
						state_d = gmlt_pkg::S_LSCAN;
					end else if (gfound_q && op_q == gmlt_pkg::OP_ADD_LINK) begin
						state_d = gmlt_pkg::S_MSCAN;
					end else begin
						state_d = gmlt_pkg::S_DONE;
					end
				end
			end
			gmlt_pkg::S_MSCAN: begin
				if (m_done) begin
					priority if (mfound_q && op_q == gmlt_pkg::OP_DEL_MEMBER) begin
						state_d = gmlt_pkg::S_LSCAN;
					end else if (mfound_q && op_q == gmlt_pkg::OP_ADD_LINK) begin
						state_d = gmlt_pkg::S_LADD;
					end else begin
						state_d = gmlt_pkg::S_DONE;
					end
				end
			end
			gmlt_pkg::S_LSCAN: begin
				if (l_done) begin
					state_d = gmlt_pkg::S_DONE;
				end
			end
			gmlt_pkg::S_DONE: begin
				if (push_ready) begin
					state_d = gmlt_pkg::S_IDLE;
				end
			end
			default: state_d = gmlt_pkg::S_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		req_stall = 1'b1;
		issue     = 1'b0;
		cnt_inc   = 1'b0;
		g_we      = 1'b0;
		m_we      = 1'b0;
		l_we      = 1'b0;
		st_set    = 1'b0;
		st_val    = gmlt_pkg::ST_OK;
		clr_gused = 1'b0;
		clr_mused = 1'b0;
		push      = 1'b0;
		unique case (state_q)
			gmlt_pkg::S_IDLE: begin
				req_stall = 1'b0;
			end
			gmlt_pkg::S_GADD: begin
				if (cnt_q == G_LIM) begin
					st_set = 1'b1;
					st_val = gmlt_pkg::ST_FULL;
				end else if (!gused_q[g_ca]) begin
					g_we = 1'b1;
				end else begin
					cnt_inc = 1'b1;
				end
			end
			gmlt_pkg::S_MADD: begin
				if (cnt_q == M_LIM) begin
					st_set = 1'b1;
					st_val = gmlt_pkg::ST_FULL;
				end else if (!mused_q[m_ca]) begin
					m_we = 1'b1;
				end else begin
					cnt_inc = 1'b1;
				end
			end
			gmlt_pkg::S_LADD: begin
				if (cnt_q == L_LIM) begin
					st_set = 1'b1;
					st_val = gmlt_pkg::ST_FULL;
				end else if (!lused_q[l_ca]) begin
					l_we = 1'b1;
				end else begin
					cnt_inc = 1'b1;
				end
			end
			gmlt_pkg::S_GSCAN: begin
				issue   = (cnt_q != G_LIM);
				cnt_inc = issue;
				if (g_done && op_q != gmlt_pkg::OP_COUNT) begin
					if (!gfound_q) begin
						st_set = 1'b1;
						st_val = gmlt_pkg::ST_NOT_FOUND;
					end else if (op_q == gmlt_pkg::OP_DEL_GROUP) begin
						clr_gused = 1'b1;
					end
				end
			end
			gmlt_pkg::S_MSCAN: begin
				issue   = (cnt_q != M_LIM);
				cnt_inc = issue;
				if (m_done) begin
					if (!mfound_q) begin
						st_set = 1'b1;
						st_val = gmlt_pkg::ST_NOT_FOUND;
					end else if (op_q == gmlt_pkg::OP_DEL_MEMBER) begin
						clr_mused = 1'b1;
					end
				end
			end
			gmlt_pkg::S_LSCAN: begin
				issue   = (cnt_q != L_LIM);
				cnt_inc = issue;
			end
			gmlt_pkg::S_DONE: begin
				push = 1'b1;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmlt_pkg::S_IDLE;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			gused_q <= '0;
			mused_q <= '0;
			lused_q <= '0;
			stamp_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			v_s1 <= issue;
			if (g_we) begin
				gused_q[g_ca] <= 1'b1;
				stamp_q <= stamp_q + 1'b1;
			end
			if (m_we) begin
				mused_q[m_ca] <= 1'b1;
				stamp_q <= stamp_q + 1'b1;
			end
			if (l_we) begin
				lused_q[l_ca] <= 1'b1;
			end
			if (clr_gused) begin
				gused_q[gbest_q] <= 1'b0;
			end
			if (clr_mused) begin
				mused_q[mbest_q] <= 1'b0;
			end
			// Links that refer to the deleted slot are freed during the link walk.
			if (state_q == gmlt_pkg::S_LSCAN && v_s1 && lused_q[l_i1]) begin
				if ((op_q == gmlt_pkg::OP_DEL_GROUP && l_rd_g == gbest_q) ||
					(op_q == gmlt_pkg::OP_DEL_MEMBER && l_rd_m == mbest_q)) begin
					lused_q[l_i1] <= 1'b0;
				end
			end
		end
	end

	// Request context and walk results; none of it needs a reset value.
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (accept) begin
			op_q     <= req.opcode;
			gid_q    <= ID_BITS'(req.group_id);
			mid_q    <= ID_BITS'(req.member_id);
			gfound_q <= 1'b0;
			mfound_q <= 1'b0;
			count_q  <= '0;
			status_q <= gmlt_pkg::ST_OK;
		end else begin
			if (st_set) begin
				status_q <= st_val;
			end
			// Newest group wins; a tie keeps the lower slot.
			if (state_q == gmlt_pkg::S_GSCAN && v_s1) begin
				gmatch_q[g_i1] <= gused_q[g_i1] && g_rd_key == gid_q;
				if (gused_q[g_i1] && g_rd_key == gid_q &&
					(!gfound_q || g_rd_age > gbest_age_q)) begin
					gfound_q    <= 1'b1;
					gbest_q     <= g_i1;
					gbest_age_q <= g_rd_age;
				end
			end
			// Oldest member wins; a tie keeps the lower slot.
			if (state_q == gmlt_pkg::S_MSCAN && v_s1) begin
				if (mused_q[m_i1] && m_rd_key == mid_q &&
					(!mfound_q || m_rd_age < mbest_age_q)) begin
					mfound_q    <= 1'b1;
					mbest_q     <= m_i1;
					mbest_age_q <= m_rd_age;
				end
			end
			if (state_q == gmlt_pkg::S_LSCAN && v_s1 && op_q == gmlt_pkg::OP_COUNT &&
				lused_q[l_i1] && gmatch_q[l_rd_g] && count_q != COUNT_MAX) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (g_we) begin
			gmem[g_ca] <= {gid_q, stamp_q};
		end
		g_rd_s1 <= gmem[g_ca];
	end

	always_ff @(posedge clk) begin
		if (m_we) begin
			mmem[m_ca] <= {mid_q, stamp_q};
		end
		m_rd_s1 <= mmem[m_ca];
	end

	always_ff @(posedge clk) begin
		if (l_we) begin
			lmem[l_ca] <= {gbest_q, mbest_q};
		end
		l_rd_s1 <= lmem[l_ca];
	end

	assign push_data.status       = status_q;
	assign push_data.member_count = count_q;

	gmlt_rsp_reg u_rsp_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

	// No read may be in flight once the sequencer is back at rest.
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gmlt_pkg::S_IDLE |-> !v_s1)
		else $error("walk data pending while idle");

	// A new group takes the current stamp and advances it by one.
	a_stamp_step: assert property (@(posedge clk) disable iff (!arst_n)
		g_we |=> stamp_q == $past(stamp_q) + 1'b1)
		else $error("insertion stamp did not advance");

	// A link is only placed between two slots that were found.
	a_link_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gmlt_pkg::S_LADD |-> gfound_q && mfound_q)
		else $error("link add without both endpoints");

	// At most one group slot is taken per cycle.
	a_group_growth: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> $countones(gused_q) <= $countones($past(gused_q)) + 1)
		else $error("group table grew by more than one slot");

endmodule
